// ===== src/ray_axis_plane_closest_point_unit_defines.svh =====
// assertion helpers shared by the rtl that checks itself
`ifndef RAY_AXIS_PLANE_CLOSEST_POINT_UNIT_DEFINES_SVH
`define RAY_AXIS_PLANE_CLOSEST_POINT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RAPCP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// invariant that holds at every edge out of reset
`define RAPCP_ASSERT_ALW(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== src/rapcp_pkg.sv =====
`default_nettype none

package rapcp_pkg;

	// fixed-point formats
	localparam int DIR_FRAC = 14;
	localparam int FB_SHIFT = 2 * DIR_FRAC;
	localparam int BIAS_D   = (1 << DIR_FRAC) - 1;
	localparam int BIAS_FB  = (1 << FB_SHIFT) - 1;

	// internal widths
	localparam int M_W      = 19;
	localparam int NUM_W    = 68;
	localparam int DEN_W    = 36;
	localparam int QCLAMP_W = 55;
	localparam int Q_W      = QCLAMP_W + 2;
	localparam int PROD_W   = Q_W + M_W;
	localparam int SH_W     = PROD_W - DIR_FRAC;

	// cycles from accepted start to done
	localparam int LATENCY = NUM_W + 11;

	localparam logic signed [31:0] PT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] PT_MIN = 32'sh8000_0000;

	// result codes
	localparam logic [1:0] CODE_SOLVED   = 2'd0;
	localparam logic [1:0] CODE_PARALLEL = 2'd1;
	localparam logic [1:0] CODE_BEHIND   = 2'd2;
	localparam logic [1:0] CODE_NONE     = 2'd3;

	// constraint modes
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_PLANE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_ANC_X  = 3'd1;
	localparam logic [2:0] REG_ANC_Y  = 3'd2;
	localparam logic [2:0] REG_ANC_Z  = 3'd3;
	localparam logic [2:0] REG_AXIS_A = 3'd4;
	localparam logic [2:0] REG_AXIS_B = 3'd5;
	localparam logic [2:0] REG_TOL    = 3'd6;

	typedef struct packed {
		logic signed [31:0] ray_origin_x;
		logic signed [31:0] ray_origin_y;
		logic signed [31:0] ray_origin_z;
		logic signed [15:0] ray_dir_x;
		logic signed [15:0] ray_dir_y;
		logic signed [15:0] ray_dir_z;
	} ray_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         case_code;
	} point_t;

	// what rides alongside the divider
	typedef struct packed {
		logic [2:0][31:0]    o;
		logic [2:0][M_W-1:0] m;
		logic [1:0]          code;
	} div_tag_t;

endpackage

`default_nettype wire

// ===== src/rapcp_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per pipeline stage
module rapcp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire logic [rapcp_pkg::NUM_W-1:0]   num_mag,
	input  wire logic [rapcp_pkg::DEN_W-1:0]   den_mag,
	input  wire logic                          neg,
	input  wire rapcp_pkg::div_tag_t           tag,
	output logic                               quo_valid,
	output logic [rapcp_pkg::NUM_W-1:0]        quo_mag,
	output logic                               quo_neg,
	output rapcp_pkg::div_tag_t                quo_tag
);

	localparam int NW = rapcp_pkg::NUM_W;
	localparam int DW = rapcp_pkg::DEN_W;

	logic                  valid_s [NW+1];
	logic [DW-1:0]         rem_s   [NW+1];
	logic [NW-1:0]         nq_s    [NW+1];
	logic [DW-1:0]         den_s   [NW+1];
	logic                  neg_s   [NW+1];
	rapcp_pkg::div_tag_t   tag_s   [NW+1];

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		nq_s[0]  <= num_mag;
		den_s[0] <= den_mag;
		neg_s[0] <= neg;
		tag_s[0] <= tag;
	end

	// one trial subtraction per stage, quotient bits shift in from the bottom
	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[k], nq_s[k][NW-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_s[k+1]  <= {nq_s[k][NW-2:0], ge};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign quo_valid = valid_s[NW];
	assign quo_mag   = nq_s[NW];
	assign quo_neg   = neg_s[NW];
	assign quo_tag   = tag_s[NW];

endmodule

`default_nettype wire

// ===== src/ray_axis_plane_closest_point_unit.sv =====
`default_nettype none
`include "ray_axis_plane_closest_point_unit_defines.svh"

// Ray to axis-constraint point. One ray is taken in every cycle (busy stays
// low). Its point is on point, marked by a one-cycle done strobe. The
// receiver cannot hold results off, so it must take each one as it appears.
// The pipeline is the restoring divider, an entry register and 68 one-bit
// stages, that sits between six input stages and four output stages.
// Configuration writes are always ready and must only be made while no ray
// is in flight.
module ray_axis_plane_closest_point_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rapcp_pkg::ray_t ray,
	output logic                 done,
	output rapcp_pkg::point_t    point,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [47:0]     cfg_data
);

	localparam int MW  = rapcp_pkg::M_W;
	localparam int DF  = rapcp_pkg::DIR_FRAC;
	localparam int NW  = rapcp_pkg::NUM_W;
	localparam int DW  = rapcp_pkg::DEN_W;
	localparam int QW  = rapcp_pkg::Q_W;
	localparam int QC  = rapcp_pkg::QCLAMP_W;
	localparam int PW  = rapcp_pkg::PROD_W;
	localparam int SW  = rapcp_pkg::SH_W;

	// configuration registers
	logic [1:0]         mode_q;
	logic signed [31:0] anc_q [3];
	logic [47:0]        axis_a_q;
	logic [47:0]        axis_b_q;
	logic [15:0]        tol_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 2'd0;
			anc_q[0] <= '0;
			anc_q[1] <= '0;
			anc_q[2] <= '0;
			axis_a_q <= 48'h0000_0000_4000;
			axis_b_q <= 48'h0000_4000_0000;
			tol_q    <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rapcp_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				rapcp_pkg::REG_ANC_X:  anc_q[0] <= cfg_data[31:0];
				rapcp_pkg::REG_ANC_Y:  anc_q[1] <= cfg_data[31:0];
				rapcp_pkg::REG_ANC_Z:  anc_q[2] <= cfg_data[31:0];
				rapcp_pkg::REG_AXIS_A: axis_a_q <= cfg_data;
				rapcp_pkg::REG_AXIS_B: axis_b_q <= cfg_data;
				rapcp_pkg::REG_TOL:    tol_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic is_line, is_plane;
	assign is_line  = mode_q == rapcp_pkg::MODE_LINE;
	assign is_plane = mode_q == rapcp_pkg::MODE_PLANE;

	logic signed [38:0] den_tol;
	logic signed [36:0] nd_tol;
	assign den_tol = 39'($signed({1'b0, tol_q}));
	assign nd_tol  = 37'($signed({1'b0, tol_q}));

	// unpacked views of the ray and the axes
	logic signed [31:0] org [3];
	logic signed [15:0] dir [3];
	logic signed [15:0] ax  [3];
	logic signed [15:0] bx  [3];

	assign org[0] = ray.ray_origin_x;
	assign org[1] = ray.ray_origin_y;
	assign org[2] = ray.ray_origin_z;
	assign dir[0] = ray.ray_dir_x;
	assign dir[1] = ray.ray_dir_y;
	assign dir[2] = ray.ray_dir_z;

	// pipeline valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s8, v_s9, v_s10, v_s11;
	logic div_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s1  <= start && !busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s8  <= div_valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// stage payloads
	logic signed [31:0]   o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3], o_s5 [3], o_s6 [3];
	logic signed [15:0]   d_s1 [3], d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3];
	logic signed [32:0]   oa_s1 [3], oa_s2 [3];
	logic signed [31:0]   dd_p_s1 [3], da_p_s1 [3], aa_p_s1 [3];
	logic signed [31:0]   nab_p_s1 [3], nba_p_s1 [3];
	logic signed [MW-1:0] dd_s2, db_s2, bb_s2, dd_s3, db_s3, dd_s4, db_s4;
	logic signed [MW-1:0] n_s2 [3], n_s3 [3], n_s4 [3], n_s5 [3];
	logic signed [37:0]   den_a_s3, den_b_s3;
	logic signed [34:0]   nd_p_s3 [3];
	logic signed [51:0]   nod_p_s3 [3];
	logic signed [48:0]   aoa_p_s3 [3], doa_p_s3 [3];
	logic signed [38:0]   den_s4, den_s5;
	logic signed [36:0]   nd_s4, nd_s5;
	logic signed [53:0]   num_s4, num_s5;
	logic signed [50:0]   aoa_s4, doa_s4;
	logic signed [69:0]   lna_s5, lnb_s5;
	logic [1:0]           code_s5, code_s6, code_s9, code_s10, code_s11;
	logic signed [70:0]   numer_s6;
	logic signed [38:0]   divisor_s6;
	logic signed [MW-1:0] m_s6 [3];

	// per-lane work
	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign ax[k] = $signed(axis_a_q[16*k +: 16]);
		assign bx[k] = $signed(axis_b_q[16*k +: 16]);

		// s1: offsets and first products
		always_ff @(posedge clk) begin
			o_s1[k]     <= org[k];
			d_s1[k]     <= dir[k];
			oa_s1[k]    <= 33'(org[k]) - 33'(anc_q[k]);
			dd_p_s1[k]  <= 32'(dir[k]) * 32'(dir[k]);
			da_p_s1[k]  <= 32'(dir[k]) * 32'(ax[k]);
			aa_p_s1[k]  <= 32'(ax[k]) * 32'(ax[k]);
			nab_p_s1[k] <= 32'(ax[(k+1)%3]) * 32'(bx[(k+2)%3]);
			nba_p_s1[k] <= 32'(ax[(k+2)%3]) * 32'(bx[(k+1)%3]);
		end

		// s2: normal component floored to the direction format
		logic signed [32:0] ncross;
		assign ncross = 33'(nab_p_s1[k]) - 33'(nba_p_s1[k]);

		always_ff @(posedge clk) begin
			o_s2[k]  <= o_s1[k];
			d_s2[k]  <= d_s1[k];
			oa_s2[k] <= oa_s1[k];
			n_s2[k]  <= ncross[DF +: MW];
		end

		// s3: dot product terms
		always_ff @(posedge clk) begin
			o_s3[k]     <= o_s2[k];
			d_s3[k]     <= d_s2[k];
			n_s3[k]     <= n_s2[k];
			nd_p_s3[k]  <= 35'(n_s2[k]) * 35'(d_s2[k]);
			nod_p_s3[k] <= 52'(n_s2[k]) * 52'(oa_s2[k]);
			aoa_p_s3[k] <= 49'(ax[k]) * 49'(oa_s2[k]);
			doa_p_s3[k] <= 49'(d_s2[k]) * 49'(oa_s2[k]);
		end

		always_ff @(posedge clk) begin
			o_s4[k] <= o_s3[k];
			d_s4[k] <= d_s3[k];
			n_s4[k] <= n_s3[k];
			o_s5[k] <= o_s4[k];
			d_s5[k] <= d_s4[k];
			n_s5[k] <= n_s4[k];
			o_s6[k] <= o_s5[k];
		end

		// s6: lane multiplier choice
		always_ff @(posedge clk) begin
			priority if (is_line && code_s5 == rapcp_pkg::CODE_SOLVED) begin
				m_s6[k] <= MW'(ax[k]);
			end else if (is_plane && code_s5 == rapcp_pkg::CODE_SOLVED) begin
				m_s6[k] <= MW'(d_s5[k]);
			end else if (is_plane) begin
				m_s6[k] <= n_s5[k];
			end else begin
				m_s6[k] <= '0;
			end
		end
	end

	// s2: squared lengths and cross term
	logic signed [33:0] dd_sum, db_sum, bb_sum;
	assign dd_sum = 34'(dd_p_s1[0]) + 34'(dd_p_s1[1]) + 34'(dd_p_s1[2]);
	assign db_sum = 34'(da_p_s1[0]) + 34'(da_p_s1[1]) + 34'(da_p_s1[2]);
	assign bb_sum = 34'(aa_p_s1[0]) + 34'(aa_p_s1[1]) + 34'(aa_p_s1[2]);

	always_ff @(posedge clk) begin
		dd_s2 <= dd_sum[DF +: MW];
		db_s2 <= db_sum[DF +: MW];
		bb_s2 <= bb_sum[DF +: MW];
	end

	// s3: denominator products
	always_ff @(posedge clk) begin
		dd_s3    <= dd_s2;
		db_s3    <= db_s2;
		den_a_s3 <= 38'(dd_s2) * 38'(bb_s2);
		den_b_s3 <= 38'(db_s2) * 38'(db_s2);
	end

	// s4: reductions
	always_ff @(posedge clk) begin
		dd_s4  <= dd_s3;
		db_s4  <= db_s3;
		den_s4 <= 39'(den_a_s3) - 39'(den_b_s3);
		nd_s4  <= 37'(nd_p_s3[0]) + 37'(nd_p_s3[1]) + 37'(nd_p_s3[2]);
		num_s4 <= -(54'(nod_p_s3[0]) + 54'(nod_p_s3[1]) + 54'(nod_p_s3[2]));
		aoa_s4 <= 51'(aoa_p_s3[0]) + 51'(aoa_p_s3[1]) + 51'(aoa_p_s3[2]);
		doa_s4 <= 51'(doa_p_s3[0]) + 51'(doa_p_s3[1]) + 51'(doa_p_s3[2]);
	end

	// s5: line numerator products and case decision
	logic den_small, nd_small, behind;
	logic [1:0] code_nxt;

	assign den_small = (den_s4 <= den_tol) && (den_s4 >= -den_tol);
	assign nd_small  = (nd_s4 <= nd_tol) && (nd_s4 >= -nd_tol);
	assign behind    = (num_s4 != '0) && (num_s4[53] != nd_s4[36]);

	always_comb begin
		priority if (is_line) begin
			code_nxt = den_small ? rapcp_pkg::CODE_PARALLEL : rapcp_pkg::CODE_SOLVED;
		end else if (is_plane) begin
			priority if (nd_small) begin
				code_nxt = rapcp_pkg::CODE_PARALLEL;
			end else if (behind) begin
				code_nxt = rapcp_pkg::CODE_BEHIND;
			end else begin
				code_nxt = rapcp_pkg::CODE_SOLVED;
			end
		end else begin
			code_nxt = rapcp_pkg::CODE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		lna_s5  <= 70'(aoa_s4) * 70'(dd_s4);
		lnb_s5  <= 70'(doa_s4) * 70'(db_s4);
		den_s5  <= den_s4;
		nd_s5   <= nd_s4;
		num_s5  <= num_s4;
		code_s5 <= code_nxt;
	end

	// s6: dividend and divisor; fallback divides by one
	always_ff @(posedge clk) begin
		code_s6 <= code_s5;
		priority if (is_line && code_s5 == rapcp_pkg::CODE_SOLVED) begin
			numer_s6   <= 71'(lna_s5) - 71'(lnb_s5);
			divisor_s6 <= den_s5;
		end else if (is_plane && code_s5 == rapcp_pkg::CODE_SOLVED) begin
			numer_s6   <= 71'(num_s5) <<< DF;
			divisor_s6 <= 39'(nd_s5);
		end else if (is_plane) begin
			numer_s6   <= 71'(num_s5);
			divisor_s6 <= 39'sd1;
		end else begin
			numer_s6   <= '0;
			divisor_s6 <= 39'sd1;
		end
	end

	// magnitudes into the divider
	logic [70:0]           numer_abs;
	logic [38:0]           divisor_abs;
	rapcp_pkg::div_tag_t   tag_in;
	logic [NW-1:0]         quo_mag;
	logic                  quo_neg;
	rapcp_pkg::div_tag_t   quo_tag;

	assign numer_abs   = numer_s6[70] ? 71'(-numer_s6) : 71'(numer_s6);
	assign divisor_abs = divisor_s6[38] ? 39'(-divisor_s6) : 39'(divisor_s6);

	always_comb begin
		tag_in.code = code_s6;
		for (int k = 0; k < 3; k++) begin
			tag_in.o[k] = o_s6[k];
			tag_in.m[k] = m_s6[k];
		end
	end

	rapcp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s6),
		.num_mag   (numer_abs[NW-1:0]),
		.den_mag   (divisor_abs[DW-1:0]),
		.neg       (numer_s6[70] ^ divisor_s6[38]),
		.tag       (tag_in),
		.quo_valid (div_valid),
		.quo_mag   (quo_mag),
		.quo_neg   (quo_neg),
		.quo_tag   (quo_tag)
	);

	// s8: clamp quotient (larger values saturate every coordinate with a nonzero multiplier anyway)
	logic [QW-1:0]         clamp_mag;
	logic signed [QW-1:0]  q_s8;
	rapcp_pkg::div_tag_t   tag_s8;

	assign clamp_mag = (|quo_mag[NW-1:QC]) ? (QW'(1) << QC) : QW'(quo_mag[QC-1:0]);

	always_ff @(posedge clk) begin
		q_s8   <= quo_neg ? -clamp_mag : clamp_mag;
		tag_s8 <= quo_tag;
	end

	// s9..s11 per lane: scale, truncate toward zero, offset and saturate
	logic signed [PW-1:0] prod_s9 [3];
	logic signed [31:0]   o_s9 [3], o_s10 [3];
	logic signed [SW-1:0] sh_s10 [3];
	logic signed [31:0]   pt_s11 [3];
	logic                 fb_shift;

	assign fb_shift = is_plane && code_s9 != rapcp_pkg::CODE_SOLVED;

	always_ff @(posedge clk) begin
		code_s9  <= tag_s8.code;
		code_s10 <= code_s9;
		code_s11 <= code_s10;
	end

	for (genvar k = 0; k < 3; k++) begin : g_out
		logic signed [PW-1:0] biased;
		logic signed [PW-1:0] bias;
		logic signed [31:0]   base;
		logic signed [62:0]   sum;
		logic signed [31:0]   sat;

		always_ff @(posedge clk) begin
			prod_s9[k] <= PW'(q_s8) * PW'($signed(tag_s8.m[k]));
			o_s9[k]    <= tag_s8.o[k];
		end

		assign bias   = fb_shift ? PW'(rapcp_pkg::BIAS_FB) : PW'(rapcp_pkg::BIAS_D);
		assign biased = prod_s9[k] + (prod_s9[k][PW-1] ? bias : PW'(0));

		always_ff @(posedge clk) begin
			o_s10[k]  <= o_s9[k];
			sh_s10[k] <= fb_shift ? SW'(biased >>> rapcp_pkg::FB_SHIFT) : SW'(biased >>> DF);
		end

		assign base = is_line ? anc_q[k] : o_s10[k];
		assign sum  = 63'(base) + 63'(sh_s10[k]);

		always_comb begin
			priority if (sum > 63'(rapcp_pkg::PT_MAX)) begin
				sat = rapcp_pkg::PT_MAX;
			end else if (sum < 63'(rapcp_pkg::PT_MIN)) begin
				sat = rapcp_pkg::PT_MIN;
			end else begin
				sat = sum[31:0];
			end
		end

		always_ff @(posedge clk) begin
			pt_s11[k] <= (code_s10 == rapcp_pkg::CODE_NONE) ? 32'sd0 : sat;
		end
	end

	// result
	assign done            = v_s11;
	assign point.point_x   = pt_s11[0];
	assign point.point_y   = pt_s11[1];
	assign point.point_z   = pt_s11[2];
	assign point.case_code = code_s11;

	`RAPCP_ASSERT_IMP(a_fixed_latency, done, $past(start, rapcp_pkg::LATENCY),
		"done without matching start")
	`RAPCP_ASSERT_IMP(a_none_zero, done && point.case_code == rapcp_pkg::CODE_NONE,
		point.point_x == 32'sd0 && point.point_y == 32'sd0 && point.point_z == 32'sd0,
		"no-mode point not zero")
	`RAPCP_ASSERT_IMP(a_line_parallel_anchor,
		done && is_line && point.case_code == rapcp_pkg::CODE_PARALLEL,
		point.point_x == anc_q[0] && point.point_y == anc_q[1] && point.point_z == anc_q[2],
		"degenerate line result is not the anchor")
	`RAPCP_ASSERT_ALW(a_code_matches_mode,
		!done || ((point.case_code == rapcp_pkg::CODE_NONE) == (!is_line && !is_plane)),
		"case code disagrees with mode")
	`RAPCP_ASSERT_IMP(a_behind_plane_only, done && point.case_code == rapcp_pkg::CODE_BEHIND,
		is_plane, "behind-origin code outside plane mode")

endmodule

`default_nettype wire
